[rtl/bdtc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdtc_pkg
// Shared types and constants for the byte / decimal text codec.
// ----------------------------------------------------------------------------
package bdtc_pkg;

    localparam int CHAR_W    = 8;
    localparam int MAX_CHARS = 5;              // "-128."
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [CHAR_W-1:0] DOT_CHAR   = 8'h2E;
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;
    localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'h30;
    localparam logic [CHAR_W-1:0] NINE_CHAR  = 8'h39;
    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
    localparam logic [CHAR_W-1:0] TAB_CHAR   = 8'h09;
    localparam logic [CHAR_W-1:0] CR_CHAR    = 8'h0D;

    typedef logic [MAX_CHARS-1:0][CHAR_W-1:0] char_vec_t;

    // One queued job: the characters of one input's results, first in [0]
    typedef struct packed {
        char_vec_t        chars;
        logic [CNT_W-1:0] count;
    } job_t;

endpackage

[rtl/bdtc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdtc_front
// Accepts input bytes, holds the mode register and the parse state, and
// turns each transaction into a job of output characters (or none).
// ----------------------------------------------------------------------------
module bdtc_front import bdtc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAR_W-1:0] s_in_byte,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              q_ready,
    output logic              push_valid,
    output job_t              push_job
);

    localparam logic [1:0] PHASE_SKIP   = 2'd0;
    localparam logic [1:0] PHASE_SIGN   = 2'd1;
    localparam logic [1:0] PHASE_DIGITS = 2'd2;
    localparam logic [1:0] PHASE_DONE   = 2'd3;

    logic              encode_mode_reg;
    logic [CHAR_W-1:0] acc_reg, acc_next;
    logic              neg_reg, neg_next;
    logic [1:0]        phase_reg, phase_next;

    logic              accept;
    logic              is_dot, is_digit, is_blank, is_sign;

    // encode datapath
    logic              b_neg;
    logic [CHAR_W-1:0] mag;
    logic              hund;
    logic [6:0]        rem;
    logic [14:0]       prod;
    logic [3:0]        tens;
    logic [6:0]        tens_x10;
    logic [3:0]        ones;
    logic [CNT_W-1:0]  n;
    char_vec_t         enc_chars;

    // decode datapath
    logic [CHAR_W-1:0] digit_val;
    logic [CHAR_W-1:0] dec_val;

    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;

    assign is_dot   = (s_in_byte == DOT_CHAR);
    assign is_digit = (s_in_byte >= ZERO_CHAR) && (s_in_byte <= NINE_CHAR);
    assign is_blank = (s_in_byte == SPACE_CHAR) ||
                      ((s_in_byte >= TAB_CHAR) && (s_in_byte <= CR_CHAR));
    assign is_sign  = (s_in_byte == PLUS_CHAR) || (s_in_byte == MINUS_CHAR);

    // Byte to digits: magnitude is at most 128, so hundreds is 0 or 1;
    // tens by reciprocal multiply (205 / 2048), exact below 100.
    assign b_neg    = s_in_byte[CHAR_W-1];
    assign mag      = b_neg ? CHAR_W'(~s_in_byte + 8'd1) : s_in_byte;
    assign hund     = (mag >= 8'd100);
    assign rem      = hund ? 7'(mag - 8'd100) : mag[6:0];
    assign prod     = 15'(rem) * 15'd205;
    assign tens     = prod[14:11];
    assign tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
    assign ones     = 4'(rem - tens_x10);

    always_comb begin
        enc_chars = '0;
        n         = '0;
        if (b_neg) begin
            enc_chars[n[2:0]] = MINUS_CHAR;
            n = n + 1'b1;
        end
        if (hund) begin
            enc_chars[n[2:0]] = ZERO_CHAR + 8'd1;
            n = n + 1'b1;
        end
        if (hund || (tens != 4'd0)) begin
            enc_chars[n[2:0]] = ZERO_CHAR + CHAR_W'(tens);
            n = n + 1'b1;
        end
        enc_chars[n[2:0]] = ZERO_CHAR + CHAR_W'(ones);
        n = n + 1'b1;
        enc_chars[n[2:0]] = DOT_CHAR;
        n = n + 1'b1;
    end

    assign digit_val = s_in_byte - ZERO_CHAR;
    assign dec_val   = neg_reg ? CHAR_W'(~acc_reg + 8'd1) : acc_reg;

    always_comb begin
        push_job = '0;
        if (encode_mode_reg) begin
            push_job.chars = enc_chars;
            push_job.count = n;
        end else begin
            push_job.chars[0] = dec_val;
            push_job.count    = CNT_W'(1);
        end
    end

    assign push_valid = accept && (encode_mode_reg || is_dot);

    // atoi-style parse; state is left alone while encoding
    always_comb begin
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        phase_next = phase_reg;
        if (accept && !encode_mode_reg) begin
            if (is_dot) begin
                acc_next   = '0;
                neg_next   = 1'b0;
                phase_next = PHASE_SKIP;
            end else if (is_digit && (phase_reg != PHASE_DONE)) begin
                acc_next   = CHAR_W'({acc_reg[4:0], 3'b000}) +
                             CHAR_W'({acc_reg[6:0], 1'b0}) + digit_val;
                phase_next = PHASE_DIGITS;
            end else if ((phase_reg == PHASE_SKIP) && is_blank) begin
                phase_next = PHASE_SKIP;
            end else if ((phase_reg == PHASE_SKIP) && is_sign) begin
                neg_next   = (s_in_byte == MINUS_CHAR);
                phase_next = PHASE_SIGN;
            end else begin
                phase_next = PHASE_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            encode_mode_reg <= 1'b1;
            acc_reg         <= '0;
            neg_reg         <= 1'b0;
            phase_reg       <= PHASE_SKIP;
        end else begin
            if (cfg_we) begin
                encode_mode_reg <= cfg_wdata;
            end
            acc_reg   <= acc_next;
            neg_reg   <= neg_next;
            phase_reg <= phase_next;
        end
    end

    a_dot_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !encode_mode_reg && is_dot |=>
            (phase_reg == PHASE_SKIP) && (acc_reg == '0) && !neg_reg)
        else $error("token state not cleared after dot");

    a_job_count: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> (push_job.count != '0) &&
                       (push_job.count <= CNT_W'(MAX_CHARS)))
        else $error("job character count out of range");

endmodule

[rtl/bdtc_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdtc_queue
// Short job queue between front and back ends.
// ----------------------------------------------------------------------------
module bdtc_queue import bdtc_pkg::*; #(
    parameter int Depth = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    input  job_t push_job,
    output logic push_ready,
    output logic head_valid,
    output job_t head_job,
    input  logic pop
);

    localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CNT_Q = $clog2(Depth + 1);

    job_t             mem_reg [Depth];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_Q-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_Q'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_Q'(Depth))
        else $error("queue occupancy above depth");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) || (count_reg == CNT_Q'(Depth)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with occupancy");

endmodule

[rtl/bdtc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdtc_back
// Serialises queued jobs into one output character per cycle while m_ready
// is high, last flag on the final character of each job.
// ----------------------------------------------------------------------------
module bdtc_back import bdtc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  job_t              head_job,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_out_byte,
    output logic              m_last
);

    char_vec_t         sr_reg, sr_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] m_out_byte_reg, m_out_byte_next;
    logic              m_last_reg, m_last_next;
    logic              out_free;

    assign out_free = !m_valid_reg || m_ready;

    // Next job's first character is taken straight from the queue head, so
    // jobs follow each other without a gap.
    always_comb begin
        sr_next         = sr_reg;
        rem_next        = rem_reg;
        m_valid_next    = m_valid_reg;
        m_out_byte_next = m_out_byte_reg;
        m_last_next     = m_last_reg;
        pop             = 1'b0;
        if (out_free) begin
            if (rem_reg != '0) begin
                m_valid_next    = 1'b1;
                m_out_byte_next = sr_reg[0];
                m_last_next     = (rem_reg == CNT_W'(1));
                sr_next         = sr_reg >> CHAR_W;
                rem_next        = rem_reg - 1'b1;
            end else if (head_valid) begin
                m_valid_next    = 1'b1;
                m_out_byte_next = head_job.chars[0];
                m_last_next     = (head_job.count == CNT_W'(1));
                sr_next         = head_job.chars >> CHAR_W;
                rem_next        = head_job.count - 1'b1;
                pop             = 1'b1;
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sr_reg         <= sr_next;
        m_out_byte_reg <= m_out_byte_next;
        m_last_reg     <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_out_byte_reg;
    assign m_last     = m_last_reg;

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg < CNT_W'(MAX_CHARS))
        else $error("remaining character count out of range");

    a_mid_job: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_last_reg |-> rem_reg != '0)
        else $error("job ended without a last character");

    a_no_pop_mid_job: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (rem_reg == '0) && head_valid)
        else $error("queue popped while a job is still being sent");

endmodule

[rtl/byte_decimal_text_codec_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_decimal_text_codec_core
// Bytes to dot-terminated decimal text (encode) and back (decode).
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------
//  input    | s_valid / s_ready  | s_in_byte[7:0]
//  result   | m_valid / m_ready  | m_out_byte[7:0], m_last
//  config   | cfg_we             | cfg_wdata (encode_mode)
//
//  Results leave at one character per cycle, while m_ready is high, from the
//  back end's output register: an encoded byte gives 2 to 5 characters
//  ("0." .. "-128."); in decode, '.' gives one result and others none.
//  After its transaction is accepted, a job passes the queue, then the output
//  register, before its first result is valid.
//  aresetn is synchronous; reset sets encode_mode to 1 and clears the parser.
//  m_ready low holds the result; up to QueueDepth jobs wait, then s_ready drops.
// ----------------------------------------------------------------------------
module byte_decimal_text_codec_core import bdtc_pkg::*; #(
    parameter int QueueDepth = QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAR_W-1:0] s_in_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_out_byte,
    output logic              m_last,
    input  logic              cfg_we,
    input  logic              cfg_wdata
);

    logic push_valid, push_ready;
    job_t push_job;
    logic head_valid, pop;
    job_t head_job;

    bdtc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .q_ready    (push_ready),
        .push_valid (push_valid),
        .push_job   (push_job)
    );

    bdtc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    bdtc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_last     (m_last)
    );

endmodule
